@@ hw/rtl/slpq_pkg.sv @@
// ----------------------------------------------------------------------------
// slpq_pkg
// shared types, codes and defaults for the sorted list priority queues
// ----------------------------------------------------------------------------
package slpq_pkg;

  localparam int unsigned NumQueueSetsDefault = 4;
  localparam int unsigned QueueDepthDefault   = 64;

  localparam int unsigned OpW    = 3;
  localparam int unsigned StatW  = 2;
  localparam int unsigned DataW  = 32;
  localparam int unsigned CapW   = 7;
  localparam int unsigned SelW   = 2;

  localparam logic [CapW-1:0] CapReset = 7'd64;

  localparam logic [OpW-1:0] OP_INSERT  = 3'd0;
  localparam logic [OpW-1:0] OP_PEEK    = 3'd1;
  localparam logic [OpW-1:0] OP_POP     = 3'd2;
  localparam logic [OpW-1:0] OP_EXTRACT = 3'd3;
  localparam logic [OpW-1:0] OP_SEARCH  = 3'd4;
  localparam logic [OpW-1:0] OP_CLEAR   = 3'd5;

  localparam logic [StatW-1:0] ST_OK   = 2'd0;
  localparam logic [StatW-1:0] ST_MISS = 2'd1;
  localparam logic [StatW-1:0] ST_FULL = 2'd2;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic             ins;
    logic             pop;
    logic             ext;
    logic [DataW-1:0] key;
    logic [DataW-1:0] value;
  } cell_cmd_t;

  // compare flags handed from a cell to its right neighbour
  typedef struct packed {
    logic lt;
    logic le;
  } cell_flags_t;

endpackage

@@ hw/rtl/slpq_cell.sv @@
// ----------------------------------------------------------------------------
// slpq_cell
// one slot position of every queue, with compare and shift to neighbours
// ----------------------------------------------------------------------------
module slpq_cell
  import slpq_pkg::*;
#(
  parameter int unsigned NUM_QUEUE_SETS = NumQueueSetsDefault,
  parameter int unsigned QUEUE_DEPTH    = QueueDepthDefault,
  parameter int unsigned IDX            = 0,
  localparam int unsigned QW = (NUM_QUEUE_SETS > 1) ? $clog2(NUM_QUEUE_SETS) : 1,
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic             clk,
  input  logic [QW-1:0]    q,
  input  logic [CW-1:0]    n,
  input  cell_cmd_t        cmd,
  input  cell_flags_t      left_flags,
  input  logic [DataW-1:0] left_key,
  input  logic [DataW-1:0] left_value,
  input  logic [DataW-1:0] right_key,
  input  logic [DataW-1:0] right_value,
  output cell_flags_t      flags,
  output logic [DataW-1:0] own_key,
  output logic [DataW-1:0] own_value,
  output logic             sel
);

  logic [DataW-1:0] key_r [NUM_QUEUE_SETS];
  logic [DataW-1:0] val_r [NUM_QUEUE_SETS];
  logic             in_cnt;
  logic             we;
  logic [DataW-1:0] key_nxt;
  logic [DataW-1:0] val_nxt;

  assign own_key   = key_r[q];
  assign own_value = val_r[q];
  assign in_cnt    = CW'(IDX) < n;
  assign flags     = {in_cnt && (own_key < cmd.key), in_cnt && (own_key <= cmd.key)};
  assign sel       = in_cnt && !flags.lt && left_flags.lt && (own_key == cmd.key);

  always_comb begin
    we      = 1'b0;
    key_nxt = right_key;
    val_nxt = right_value;
    if (cmd.ins) begin
      we = !flags.le;
      if (left_flags.le) begin
        key_nxt = cmd.key;
        val_nxt = cmd.value;
      end else begin
        key_nxt = left_key;
        val_nxt = left_value;
      end
    end else if (cmd.pop) begin
      we = 1'b1;
    end else if (cmd.ext) begin
      we = !flags.lt;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      key_r[q] <= key_nxt;
      val_r[q] <= val_nxt;
    end
  end

endmodule

@@ hw/rtl/sorted_list_priority_queue_unit.sv @@
// ----------------------------------------------------------------------------
// sorted_list_priority_queue_unit
// several key/value priority queues kept sorted in a row of slot cells
// ----------------------------------------------------------------------------
// usage:
//   in_* channel carries one operation transaction (insert, peek, pop,
//   extract, search, clear) for the queue picked by in_queue_select.
//   out_* channel returns exactly one result transaction per operation.
//   cfg_* channel writes capacity_limit; always ready, write only when idle.
// timing:
//   a transaction is registered when taken and executed in a later cycle,
//   in which every cell compares its entry with the key and shifts with its
//   neighbour at once; the result is registered. a new transaction is taken
//   only once the previous one has executed. the execute cycle waits while a
//   previous result is still held in the output register.
// reset:
//   all queues empty, capacity_limit 64, no result pending.
// stall:
//   while out_ready is low the result holds and at most one further
//   transaction is taken and held until the output register frees.
// ----------------------------------------------------------------------------
module sorted_list_priority_queue_unit
  import slpq_pkg::*;
#(
  parameter int unsigned NUM_QUEUE_SETS = NumQueueSetsDefault,
  parameter int unsigned QUEUE_DEPTH    = QueueDepthDefault
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [OpW-1:0]   in_operation,
  input  logic [SelW-1:0]  in_queue_select,
  input  logic [DataW-1:0] in_key_in,
  input  logic [DataW-1:0] in_value_in,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [StatW-1:0] out_status,
  output logic [DataW-1:0] out_key_out,
  output logic [DataW-1:0] out_value_out,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CapW-1:0]  cfg_capacity_limit
);

  localparam int unsigned QW = (NUM_QUEUE_SETS > 1) ? $clog2(NUM_QUEUE_SETS) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned MW = (CW > CapW) ? CW : CapW;

  logic             busy_r;
  logic [OpW-1:0]   op_r;
  logic [QW-1:0]    q_r;
  logic [DataW-1:0] key_r;
  logic [DataW-1:0] val_r;
  logic [CapW-1:0]  cap_r;
  logic [CW-1:0]    cnt_r [NUM_QUEUE_SETS];

  logic             out_valid_r;
  logic [StatW-1:0] out_status_r;
  logic [DataW-1:0] out_key_r;
  logic [DataW-1:0] out_value_r;

  logic             exec;
  logic [QW-1:0]    q_nxt;
  logic [CW-1:0]    n;
  logic [MW-1:0]    cap_eff;
  logic             full;
  logic             hit;
  logic [DataW-1:0] hit_key;
  logic [DataW-1:0] hit_value;
  logic [StatW-1:0] stat_nxt;
  logic [DataW-1:0] okey_nxt;
  logic [DataW-1:0] oval_nxt;
  logic [CW-1:0]    cnt_nxt;
  cell_cmd_t        cmd;

  cell_flags_t      fl   [QUEUE_DEPTH];
  logic [DataW-1:0] ck   [QUEUE_DEPTH];
  logic [DataW-1:0] cv   [QUEUE_DEPTH];
  logic             csel [QUEUE_DEPTH];

  assign in_ready      = !busy_r;
  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_key_out   = out_key_r;
  assign out_value_out = out_value_r;

  assign exec = busy_r && (!out_valid_r || out_ready);

  // queue select wraps over the number of queues
  always_comb begin
    logic [SelW:0] s;
    s = {1'b0, in_queue_select};
    for (int k = 0; k < 4; k++) begin
      if (s >= (SelW+1)'(NUM_QUEUE_SETS)) begin
        s = s - (SelW+1)'(NUM_QUEUE_SETS);
      end
    end
    q_nxt = QW'(s);
  end

  assign n       = cnt_r[q_r];
  assign cap_eff = (MW'(cap_r) > MW'(QUEUE_DEPTH)) ? MW'(QUEUE_DEPTH) : MW'(cap_r);
  assign full    = MW'(n) >= cap_eff;

  always_comb begin
    hit       = 1'b0;
    hit_key   = '0;
    hit_value = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      hit       = hit | csel[i];
      hit_key   = hit_key | (csel[i] ? ck[i] : '0);
      hit_value = hit_value | (csel[i] ? cv[i] : '0);
    end
  end

  always_comb begin
    cmd.ins   = exec && (op_r == OP_INSERT) && !full;
    cmd.pop   = exec && (op_r == OP_POP) && (n != '0);
    cmd.ext   = exec && (op_r == OP_EXTRACT) && hit;
    cmd.key   = key_r;
    cmd.value = val_r;
  end

  always_comb begin
    stat_nxt = ST_MISS;
    okey_nxt = '0;
    oval_nxt = '0;
    cnt_nxt  = n;
    case (op_r)
      OP_INSERT: begin
        if (full) begin
          stat_nxt = ST_FULL;
        end else begin
          stat_nxt = ST_OK;
          cnt_nxt  = n + 1'b1;
        end
      end
      OP_PEEK, OP_POP: begin
        if (n != '0) begin
          stat_nxt = ST_OK;
          okey_nxt = ck[0];
          oval_nxt = cv[0];
          if (op_r == OP_POP) begin
            cnt_nxt = n - 1'b1;
          end
        end
      end
      OP_EXTRACT, OP_SEARCH: begin
        if (hit) begin
          stat_nxt = ST_OK;
          okey_nxt = hit_key;
          oval_nxt = hit_value;
          if (op_r == OP_EXTRACT) begin
            cnt_nxt = n - 1'b1;
          end
        end
      end
      OP_CLEAR: begin
        stat_nxt = ST_OK;
        cnt_nxt  = '0;
      end
      default: begin
        stat_nxt = ST_MISS;
      end
    endcase
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    cell_flags_t      lf;
    logic [DataW-1:0] lk, lv, rk, rv;
    if (i == 0) begin : g_first
      assign lf = '1;
      assign lk = '0;
      assign lv = '0;
    end else begin : g_mid
      assign lf = fl[i-1];
      assign lk = ck[i-1];
      assign lv = cv[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign rk = '0;
      assign rv = '0;
    end else begin : g_next
      assign rk = ck[i+1];
      assign rv = cv[i+1];
    end
    slpq_cell #(
      .NUM_QUEUE_SETS(NUM_QUEUE_SETS),
      .QUEUE_DEPTH   (QUEUE_DEPTH),
      .IDX           (i)
    ) u_cell (
      .clk        (clk),
      .q          (q_r),
      .n          (n),
      .cmd        (cmd),
      .left_flags (lf),
      .left_key   (lk),
      .left_value (lv),
      .right_key  (rk),
      .right_value(rv),
      .flags      (fl[i]),
      .own_key    (ck[i]),
      .own_value  (cv[i]),
      .sel        (csel[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      cap_r       <= CapReset;
      for (int k = 0; k < NUM_QUEUE_SETS; k++) begin
        cnt_r[k] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_capacity_limit;
      end
      if (in_valid && in_ready) begin
        busy_r <= 1'b1;
      end else if (exec) begin
        busy_r <= 1'b0;
      end
      if (exec) begin
        out_valid_r <= 1'b1;
        cnt_r[q_r]  <= cnt_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r  <= in_operation;
      q_r   <= q_nxt;
      key_r <= in_key_in;
      val_r <= in_value_in;
    end
    if (exec) begin
      out_status_r <= stat_nxt;
      out_key_r    <= okey_nxt;
      out_value_r  <= oval_nxt;
    end
  end

endmodule

@@ tb/sorted_list_priority_queue_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_priority_queue_unit_test
// drives operations into the priority queue unit and checks every result
// against an in-bench model of the queues, under random gaps and stalls
// ----------------------------------------------------------------------------
module sorted_list_priority_queue_unit_test;
  import slpq_pkg::*;

  localparam int NQ = 4;
  localparam int DEPTH = 64;

  // operation codes with no meaning
  localparam logic [OpW-1:0] OP_RSVD_LO = 3'd6;
  localparam logic [OpW-1:0] OP_RSVD_HI = 3'd7;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [DataW-1:0] key;
    logic [DataW-1:0] value;
  } result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [OpW-1:0]   in_operation = OP_INSERT;
  logic [SelW-1:0]  in_queue_select = '0;
  logic [DataW-1:0] in_key_in = '0;
  logic [DataW-1:0] in_value_in = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [StatW-1:0] out_status;
  logic [DataW-1:0] out_key_out;
  logic [DataW-1:0] out_value_out;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CapW-1:0]  cfg_capacity_limit = '0;

  // model of the queues
  logic [DataW-1:0] q_keys[NQ][$];
  logic [DataW-1:0] q_values[NQ][$];
  logic [CapW-1:0]  cap_limit;
  result_t          pending_results[$];
  int               error_count = 0;
  bit               stall_enable = 1'b1;

  sorted_list_priority_queue_unit uut (.*);

  always #4 clk = ~clk;

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic result_t queue_apply(logic [OpW-1:0] op, logic [SelW-1:0] sel,
                                         logic [DataW-1:0] key, logic [DataW-1:0] value);
    result_t r;
    int q;
    int n;
    int lim;
    int pos;
    q = sel % NQ;
    n = q_keys[q].size();
    lim = (cap_limit > DEPTH) ? DEPTH : cap_limit;
    r = '{ST_MISS, '0, '0};
    case (op)
      OP_INSERT: begin
        if (n >= lim) begin
          r.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < n && q_keys[q][pos] <= key) pos++;
          q_keys[q].insert(pos, key);
          q_values[q].insert(pos, value);
          r.status = ST_OK;
        end
      end
      OP_PEEK, OP_POP: begin
        if (n > 0) begin
          r = '{ST_OK, q_keys[q][0], q_values[q][0]};
          if (op == OP_POP) begin
            q_keys[q].delete(0);
            q_values[q].delete(0);
          end
        end
      end
      OP_EXTRACT, OP_SEARCH: begin
        pos = -1;
        for (int i = 0; i < n; i++)
          if (pos < 0 && q_keys[q][i] == key) pos = i;
        if (pos >= 0) begin
          r = '{ST_OK, q_keys[q][pos], q_values[q][pos]};
          if (op == OP_EXTRACT) begin
            q_keys[q].delete(pos);
            q_values[q].delete(pos);
          end
        end
      end
      OP_CLEAR: begin
        q_keys[q].delete();
        q_values[q].delete();
        r.status = ST_OK;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [DataW-1:0] got, logic [DataW-1:0] exp);
    $display("mismatch %s: got %h expected %h at %0t", what, got, exp, $realtime);
    error_count++;
  endtask

  task automatic send_op(logic [OpW-1:0] op, logic [SelW-1:0] sel,
                         logic [DataW-1:0] key, logic [DataW-1:0] value);
    int g;
    g = gap_len();
    @(posedge clk);
    repeat (g) @(posedge clk);
    in_valid <= 1'b1;
    in_operation <= op;
    in_queue_select <= sel;
    in_key_in <= key;
    in_value_in <= value;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(queue_apply(op, sel, key, value));
    in_valid <= 1'b0;
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CapW-1:0] v);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_capacity_limit <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cap_limit = v;
  endtask

  // result checker
  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", {30'd0, out_status}, '0);
      end else begin
        e = pending_results.pop_front();
        if (out_status != e.status) report_mismatch("status", out_status, e.status);
        if (out_key_out != e.key) report_mismatch("key", out_key_out, e.key);
        if (out_value_out != e.value) report_mismatch("value", out_value_out, e.value);
      end
    end
  end

  // result side stalls
  always @(posedge clk) begin
    if (!stall_enable) out_ready <= 1'b1;
    else if ($urandom_range(0, 99) < 8) out_ready <= ~out_ready;
    else if (!out_ready && $urandom_range(0, 99) < 30) out_ready <= 1'b1;
  end

  task automatic test_directed();
    send_op(OP_PEEK, 0, 0, 0);
    send_op(OP_POP, 1, 0, 0);
    send_op(OP_SEARCH, 2, 5, 0);
    send_op(OP_INSERT, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(OP_INSERT, 0, 32'h0, 32'h1);
    send_op(OP_INSERT, 0, 32'h10, 32'hAAAA_5555);
    send_op(OP_INSERT, 0, 32'h10, 32'h5555_AAAA);
    send_op(OP_PEEK, 0, 0, 0);
    send_op(OP_SEARCH, 0, 32'h10, 0);
    send_op(OP_EXTRACT, 0, 32'h10, 0);
    send_op(OP_EXTRACT, 0, 32'h11, 0);
    send_op(OP_POP, 0, 0, 0);
    send_op(OP_INSERT, 3, 32'h8000_0000, 32'h7);
    send_op(OP_CLEAR, 3, 0, 0);
    send_op(OP_PEEK, 3, 0, 0);
    send_op(OP_RSVD_LO, 0, 0, 0);
    send_op(OP_RSVD_HI, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(OP_POP, 0, 0, 0);
    send_op(OP_POP, 0, 0, 0);
  endtask

  task automatic test_capacity();
    write_capacity(7'd0);
    send_op(OP_INSERT, 1, 1, 1);
    write_capacity(7'd2);
    repeat (3) send_op(OP_INSERT, 1, $urandom, $urandom);
    write_capacity(7'd1);
    send_op(OP_INSERT, 1, 3, 3);
    write_capacity(7'd127);
    for (int i = 0; i < 66; i++) send_op(OP_INSERT, 2, $urandom_range(0, 20), i);
    send_op(OP_CLEAR, 2, 0, 0);
    send_op(OP_CLEAR, 1, 0, 0);
    write_capacity(7'd64);
  endtask

  task automatic test_random(int count);
    logic [OpW-1:0] op;
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 40) op = OP_INSERT;
      else if (r < 52) op = OP_PEEK;
      else if (r < 66) op = OP_POP;
      else if (r < 78) op = OP_EXTRACT;
      else if (r < 90) op = OP_SEARCH;
      else if (r < 94) op = OP_CLEAR;
      else op = ($urandom_range(0, 1) == 0) ? OP_RSVD_LO : OP_RSVD_HI;
      if (i == count / 2) drain_results();
      if (i == count / 4) write_capacity(CapW'($urandom_range(3, 12)));
      if (i == (3 * count) / 4) write_capacity(7'd64);
      stall_enable = (i % 100) >= 20;
      send_op(op, SelW'($urandom_range(0, 3)),
              ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 15), $urandom);
    end
    stall_enable = 1'b1;
  endtask

  initial begin
    cap_limit = CapReset;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_capacity();
    test_random(310);
    drain_results();
    repeat (10) @(posedge clk);
    if (error_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

@@ sorted_list_priority_queue_unit.f @@
hw/rtl/slpq_pkg.sv
hw/rtl/slpq_cell.sv
hw/rtl/sorted_list_priority_queue_unit.sv
tb/sorted_list_priority_queue_unit_test.sv
